// ===== src/ftri_pkg.sv =====
// ---------------------------------------------------------------------------
// Face triangulator package
// Types and constants shared by the front end, the face queue and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package ftri_pkg;

    // two vertex buffer banks: one fills while the other is processed
    localparam int NUM_BANKS = 2;
    localparam int BANK_W    = 1;

    localparam logic KIND_TRI   = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [BANK_W-1:0]   bank;
    } t_bank_rel;

endpackage

`default_nettype wire

// ===== src/face_triangulator_core.sv =====
// ---------------------------------------------------------------------------
// Face triangulator core
// Splits polygon faces, streamed one vertex word at a time, into triangles;
// faces other than triangles and quads get a centroid point and a fan.
// ---------------------------------------------------------------------------
//  channel   | handshake         | words
//  ----------+-------------------+-----------------------------------------
//  vertex in | push / full       | index, x, y, z, face_end
//  result    | empty / pop       | kind, corners a/b/c, center x/y/z, last
//  config    | i_cfg_we          | first new point index
//
//  Vertices enter at one per cycle into one of two buffer banks; a full bank
//  pair holds off push. A quad's time is set by the bit-serial multiplier,
//  which forms thirty-eight products of up to 272 bits. Other faces run the
//  centroid divider once per coordinate, then emit one fan triangle per edge.
//  Reset is synchronous and clears the queue, the bank flags and the point
//  counter. A held result that is not popped stalls the back.
// ---------------------------------------------------------------------------
`default_nettype none

module face_triangulator_core #(
    parameter int MAX_FACE_SIZE = 16,
    parameter int COORD_WIDTH   = 32,
    parameter int INDEX_WIDTH   = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [INDEX_WIDTH-1:0]  i_cfg_wdata,
    input  logic                    push,
    output logic                    full,
    input  logic [INDEX_WIDTH-1:0]  i_vertex_index,
    input  logic [COORD_WIDTH-1:0]  i_vertex_x,
    input  logic [COORD_WIDTH-1:0]  i_vertex_y,
    input  logic [COORD_WIDTH-1:0]  i_vertex_z,
    input  logic                    i_face_end,
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_item_kind,
    output logic [INDEX_WIDTH-1:0]  o_corner_a,
    output logic [INDEX_WIDTH-1:0]  o_corner_b,
    output logic [INDEX_WIDTH-1:0]  o_corner_c,
    output logic [COORD_WIDTH-1:0]  o_center_x,
    output logic [COORD_WIDTH-1:0]  o_center_y,
    output logic [COORD_WIDTH-1:0]  o_center_z,
    output logic                    o_run_last
);
    import ftri_pkg::*;

    localparam int CNT_W = $clog2(MAX_FACE_SIZE + 1);
    localparam int AW    = $clog2(MAX_FACE_SIZE);
    localparam int SW    = COORD_WIDTH + $clog2(MAX_FACE_SIZE);
    localparam int QW    = BANK_W + CNT_W + 3 * SW;
    localparam int MEMW  = INDEX_WIDTH + 3 * COORD_WIDTH;

    logic                 wr_en;
    logic [BANK_W+AW-1:0] wr_addr;
    logic [MEMW-1:0]      wr_data;
    logic                 q_push;
    logic [QW-1:0]        q_wdata;
    logic                 q_pop;
    logic                 q_empty;
    logic [QW-1:0]        q_rdata;
    t_bank_rel            rel;

    ftri_front #(
        .MAX_FACE_SIZE (MAX_FACE_SIZE),
        .COORD_WIDTH   (COORD_WIDTH),
        .INDEX_WIDTH   (INDEX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_vertex_index (i_vertex_index),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_vertex_z     (i_vertex_z),
        .i_face_end     (i_face_end),
        .i_rel          (rel),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    ftri_fifo #(.DATA_W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    ftri_back #(
        .MAX_FACE_SIZE (MAX_FACE_SIZE),
        .COORD_WIDTH   (COORD_WIDTH),
        .INDEX_WIDTH   (INDEX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_rel       (rel),
        .empty       (empty),
        .pop         (pop),
        .o_item_kind (o_item_kind),
        .o_corner_a  (o_corner_a),
        .o_corner_b  (o_corner_b),
        .o_corner_c  (o_corner_c),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y),
        .o_center_z  (o_center_z),
        .o_run_last  (o_run_last)
    );

endmodule

`default_nettype wire

// ===== src/ftri_fifo.sv =====
// ---------------------------------------------------------------------------
// Face queue
// Short queue of face descriptors between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module ftri_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);
    import ftri_pkg::*;

    localparam int PTR_W = $clog2(NUM_BANKS);

    logic [DATA_W-1:0] r_mem [NUM_BANKS];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W:0]    r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
            priority if (i_push && !(i_pop && !o_empty)) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop && !o_empty) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ftri_front.sv =====
// ---------------------------------------------------------------------------
// Face triangulator front end
// Takes vertex words, writes them into the free buffer bank, sums the
// coordinates and queues one descriptor per face.
// ---------------------------------------------------------------------------
`default_nettype none

module ftri_front #(
    parameter int MAX_FACE_SIZE = 16,
    parameter int COORD_WIDTH   = 32,
    parameter int INDEX_WIDTH   = 32,
    localparam int CNT_W = $clog2(MAX_FACE_SIZE + 1),
    localparam int AW    = $clog2(MAX_FACE_SIZE),
    localparam int SW    = COORD_WIDTH + $clog2(MAX_FACE_SIZE),
    localparam int QW    = ftri_pkg::BANK_W + CNT_W + 3 * SW,
    localparam int MEMW  = INDEX_WIDTH + 3 * COORD_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [INDEX_WIDTH-1:0]  i_vertex_index,
    input  logic [COORD_WIDTH-1:0]  i_vertex_x,
    input  logic [COORD_WIDTH-1:0]  i_vertex_y,
    input  logic [COORD_WIDTH-1:0]  i_vertex_z,
    input  logic                    i_face_end,
    input  ftri_pkg::t_bank_rel     i_rel,
    output logic                    o_wr_en,
    output logic [ftri_pkg::BANK_W+AW-1:0] o_wr_addr,
    output logic [MEMW-1:0]         o_wr_data,
    output logic                    o_q_push,
    output logic [QW-1:0]           o_q_data
);
    import ftri_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic [BANK_W-1:0]    r_bank;
    logic [NUM_BANKS-1:0] r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [SW-1:0]        r_sx, r_sy, r_sz;

    logic             acc;
    logic             room;
    logic [CNT_W-1:0] n_cnt;
    logic [SW-1:0]    n_sx, n_sy, n_sz;

    assign full = r_busy[r_bank];
    assign acc  = push && !full;
    assign room = (r_cnt < CNT_W'(MAX_FACE_SIZE));

    always_comb begin
        n_cnt = r_cnt;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sz  = r_sz;
        if (room) begin
            n_cnt = r_cnt + 1'b1;
            n_sx  = r_sx + {{(SW-CW){i_vertex_x[CW-1]}}, i_vertex_x};
            n_sy  = r_sy + {{(SW-CW){i_vertex_y[CW-1]}}, i_vertex_y};
            n_sz  = r_sz + {{(SW-CW){i_vertex_z[CW-1]}}, i_vertex_z};
        end
    end

    assign o_wr_en   = acc && room;
    assign o_wr_addr = {r_bank, r_cnt[AW-1:0]};
    assign o_wr_data = {i_vertex_index, i_vertex_x, i_vertex_y, i_vertex_z};
    assign o_q_push  = acc && i_face_end;
    assign o_q_data  = {r_bank, n_cnt, n_sx, n_sy, n_sz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= '0;
            r_busy <= '0;
            r_cnt  <= '0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_sz   <= '0;
        end else begin
            if (i_rel.valid) begin
                r_busy[i_rel.bank] <= 1'b0;
            end
            if (acc) begin
                if (i_face_end) begin
                    r_busy[r_bank] <= 1'b1;
                    r_bank         <= r_bank + 1'b1;
                    r_cnt          <= '0;
                    r_sx           <= '0;
                    r_sy           <= '0;
                    r_sz           <= '0;
                end else begin
                    r_cnt <= n_cnt;
                    r_sx  <= n_sx;
                    r_sy  <= n_sy;
                    r_sz  <= n_sz;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ftri_mul.sv =====
// ---------------------------------------------------------------------------
// Face triangulator multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle, stops early
// once the remaining multiplier bits are zero.
// ---------------------------------------------------------------------------
`default_nettype none

module ftri_mul #(
    parameter int OP_W = 136
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OP_W-1:0]   i_a,
    input  logic [OP_W-1:0]   i_b,
    output logic [2*OP_W-1:0] o_prod,
    output logic              o_done
);
    logic [2*OP_W-1:0] r_acc;
    logic [2*OP_W-1:0] r_a;
    logic [OP_W-1:0]   r_b;
    logic              r_run;
    logic              r_done;

    assign o_prod = r_acc;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= {{OP_W{1'b0}}, i_a};
            r_b   <= i_b;
        end else if (r_run && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[2*OP_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[OP_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_b == '0)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ftri_div.sv =====
// ---------------------------------------------------------------------------
// Face triangulator divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module ftri_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 5,
    parameter int QUO_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_done
);
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DEN_W:0]   sh;
    logic             ge;
    logic [DEN_W:0]   rem_n;
    logic [NUM_W-1:0] quo_full;

    assign sh       = {r_rem, r_q[NUM_W-1]};
    assign ge       = (sh >= {1'b0, i_den});
    assign rem_n    = ge ? (sh - {1'b0, i_den}) : sh;
    assign quo_full = r_neg ? (~r_q + 1'b1) : r_q;
    assign o_quo    = quo_full[QUO_W-1:0];
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;
            r_neg <= i_num[NUM_W-1];
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_run) begin
            r_rem <= rem_n[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == CNT_W'(NUM_W - 1))) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ftri_back.sv =====
// ---------------------------------------------------------------------------
// Face triangulator back end
// Holds the banked vertex buffer, runs the quad diagonal test, the centroid
// division and the fan, and keeps the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ftri_back #(
    parameter int MAX_FACE_SIZE = 16,
    parameter int COORD_WIDTH   = 32,
    parameter int INDEX_WIDTH   = 32,
    localparam int CNT_W = $clog2(MAX_FACE_SIZE + 1),
    localparam int AW    = $clog2(MAX_FACE_SIZE),
    localparam int SW    = COORD_WIDTH + $clog2(MAX_FACE_SIZE),
    localparam int QW    = ftri_pkg::BANK_W + CNT_W + 3 * SW,
    localparam int MEMW  = INDEX_WIDTH + 3 * COORD_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [INDEX_WIDTH-1:0]  i_cfg_wdata,
    input  logic                    i_wr_en,
    input  logic [ftri_pkg::BANK_W+AW-1:0] i_wr_addr,
    input  logic [MEMW-1:0]         i_wr_data,
    input  logic                    i_q_empty,
    input  logic [QW-1:0]           i_q_data,
    output logic                    o_q_pop,
    output ftri_pkg::t_bank_rel     o_rel,
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_item_kind,
    output logic [INDEX_WIDTH-1:0]  o_corner_a,
    output logic [INDEX_WIDTH-1:0]  o_corner_b,
    output logic [INDEX_WIDTH-1:0]  o_corner_c,
    output logic [COORD_WIDTH-1:0]  o_center_x,
    output logic [COORD_WIDTH-1:0]  o_center_y,
    output logic [COORD_WIDTH-1:0]  o_center_z,
    output logic                    o_run_last
);
    import ftri_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int IW  = INDEX_WIDTH;
    localparam int DFW = CW + 1;
    localparam int PW  = 2 * DFW;
    localparam int XW  = PW + 1;
    localparam int ARW = 2 * XW + 2;
    localparam int MW  = ARW;

    typedef enum logic [23:0] {
        ST_IDLE  = 24'h000001,
        ST_RD    = 24'h000002,
        ST_CAP   = 24'h000004,
        ST_TRI   = 24'h000008,
        ST_DIFF  = 24'h000010,
        ST_MULP  = 24'h000020,
        ST_WP    = 24'h000040,
        ST_MULQ  = 24'h000080,
        ST_WQ    = 24'h000100,
        ST_MULS  = 24'h000200,
        ST_WS    = 24'h000400,
        ST_SORT  = 24'h000800,
        ST_MULL  = 24'h001000,
        ST_WL    = 24'h002000,
        ST_MULR  = 24'h004000,
        ST_WR    = 24'h008000,
        ST_Q0    = 24'h010000,
        ST_Q1    = 24'h020000,
        ST_DIV   = 24'h040000,
        ST_WD    = 24'h080000,
        ST_CEN   = 24'h100000,
        ST_FEMIT = 24'h200000,
        ST_FLAST = 24'h400000,
        ST_DONE  = 24'h800000
    } t_state;

    function automatic logic [DFW-1:0] dif(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    function automatic logic [DFW-1:0] mag(input logic [DFW-1:0] d);
        return d[DFW-1] ? (~d + 1'b1) : d;
    endfunction

    // vertex buffer
    logic [MEMW-1:0] r_mem [NUM_BANKS << AW];
    logic [MEMW-1:0] r_rd_data;

    t_state            r_state;
    logic [BANK_W-1:0] r_bank;
    logic [CNT_W-1:0]  r_n;
    logic [SW-1:0]     r_sx, r_sy, r_sz;
    logic [CNT_W-1:0]  r_k;
    logic [IW-1:0]     r_vid [4];
    logic [3*CW-1:0]   r_vp [4];
    logic [1:0]        r_area;
    logic [1:0]        r_term;
    logic [DFW-1:0]    r_dux, r_duy, r_duz, r_dvx, r_dvy, r_dvz;
    logic [PW-1:0]     r_p;
    logic              r_sp;
    logic [XW-1:0]     r_cross;
    logic [ARW-1:0]    r_acc;
    logic [ARW-1:0]    r_ar [4];
    logic [ARW-1:0]    r_mx0, r_mn0, r_mx1, r_mn1;
    logic [2*MW-1:0]   r_lhs;
    logic              r_use13;
    logic [1:0]        r_dsel;
    logic [CW-1:0]     r_cx, r_cy, r_cz;
    logic [IW-1:0]     r_next_point;
    logic [IW-1:0]     r_cid, r_first, r_prev, r_cur;

    logic              r_o_valid;
    logic              r_o_kind;
    logic [IW-1:0]     r_o_a, r_o_b, r_o_c;
    logic [CW-1:0]     r_o_x, r_o_y, r_o_z;
    logic              r_o_last;

    logic [BANK_W-1:0] q_bank;
    logic [CNT_W-1:0]  q_n;
    logic [SW-1:0]     q_sx, q_sy, q_sz;
    logic [IW-1:0]     rd_id;
    logic [3*CW-1:0]   rd_p;
    logic              is_tri, is_quad, k_last;

    logic [3*CW-1:0]   pa, pb, pc;
    logic [DFW-1:0]    op_a, op_b, op_c, op_d;
    logic [PW-1:0]     q_prod;
    logic              sq;
    logic [XW-1:0]     cross_n;
    logic [ARW-1:0]    acc_n;

    logic              mul_start;
    logic [MW-1:0]     mul_a, mul_b;
    logic [2*MW-1:0]   mul_prod;
    logic              mul_done;
    logic              div_start;
    logic [SW-1:0]     div_num;
    logic [CW-1:0]     div_quo;
    logic              div_done;

    logic              emit, out_free, out_ld;
    logic              e_kind, e_last;
    logic [IW-1:0]     e_a, e_b, e_c;
    logic [CW-1:0]     e_x, e_y, e_z;

    assign {q_bank, q_n, q_sx, q_sy, q_sz} = i_q_data;
    assign rd_id   = r_rd_data[MEMW-1 -: IW];
    assign rd_p    = r_rd_data[3*CW-1:0];
    assign is_tri  = (r_n == CNT_W'(3));
    assign is_quad = (r_n == CNT_W'(4));
    assign k_last  = ((r_k + 1'b1) == r_n);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[{r_bank, r_k[AW-1:0]}];
    end

    // corners of the current area: (pa - pb) x (pa - pc)
    always_comb begin
        unique case (r_area)
            2'd0: begin pa = r_vp[0]; pb = r_vp[1]; pc = r_vp[3]; end
            2'd1: begin pa = r_vp[1]; pb = r_vp[2]; pc = r_vp[3]; end
            2'd2: begin pa = r_vp[0]; pb = r_vp[1]; pc = r_vp[2]; end
            default: begin pa = r_vp[2]; pb = r_vp[3]; pc = r_vp[0]; end
        endcase
    end

    always_comb begin
        unique case (r_term)
            2'd1: begin op_a = r_duz; op_b = r_dvx; op_c = r_dux; op_d = r_dvz; end
            2'd2: begin op_a = r_dux; op_b = r_dvy; op_c = r_duy; op_d = r_dvx; end
            default: begin op_a = r_duy; op_b = r_dvz; op_c = r_duz; op_d = r_dvy; end
        endcase
    end

    assign q_prod = mul_prod[PW-1:0];
    assign sq     = op_c[DFW-1] ^ op_d[DFW-1];

    always_comb begin
        priority if (r_sp != sq) begin
            cross_n = {1'b0, r_p} + {1'b0, q_prod};
        end else if (r_p >= q_prod) begin
            cross_n = {1'b0, r_p} - {1'b0, q_prod};
        end else begin
            cross_n = {1'b0, q_prod} - {1'b0, r_p};
        end
    end

    assign acc_n = r_acc + ARW'(mul_prod[2*XW-1:0]);

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            ST_MULP: begin mul_start = 1'b1; mul_a = MW'(mag(op_a)); mul_b = MW'(mag(op_b)); end
            ST_MULQ: begin mul_start = 1'b1; mul_a = MW'(mag(op_c)); mul_b = MW'(mag(op_d)); end
            ST_MULS: begin mul_start = 1'b1; mul_a = MW'(r_cross); mul_b = MW'(r_cross); end
            ST_MULL: begin mul_start = 1'b1; mul_a = r_mx0; mul_b = r_mn1; end
            ST_MULR: begin mul_start = 1'b1; mul_a = r_mx1; mul_b = r_mn0; end
            default: ;
        endcase
    end

    always_comb begin
        unique case (r_dsel)
            2'd1:    div_num = r_sy;
            2'd2:    div_num = r_sz;
            default: div_num = r_sx;
        endcase
    end
    assign div_start = (r_state == ST_DIV);

    ftri_mul #(.OP_W(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    ftri_div #(.NUM_W(SW), .DEN_W(CNT_W), .QUO_W(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_n),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // result word selection
    always_comb begin
        emit   = 1'b0;
        e_kind = KIND_TRI;
        e_a    = '0;
        e_b    = '0;
        e_c    = '0;
        e_x    = '0;
        e_y    = '0;
        e_z    = '0;
        e_last = 1'b0;
        unique case (r_state)
            ST_TRI: begin
                emit = 1'b1; e_a = r_vid[0]; e_b = r_vid[1]; e_c = r_vid[2]; e_last = 1'b1;
            end
            ST_Q0: begin
                emit = 1'b1; e_a = r_vid[0]; e_b = r_vid[1];
                e_c  = r_use13 ? r_vid[3] : r_vid[2];
            end
            ST_Q1: begin
                emit = 1'b1; e_last = 1'b1;
                e_a  = r_use13 ? r_vid[1] : r_vid[2];
                e_b  = r_use13 ? r_vid[2] : r_vid[3];
                e_c  = r_use13 ? r_vid[3] : r_vid[0];
            end
            ST_CEN: begin
                emit = 1'b1; e_kind = KIND_POINT; e_a = r_next_point;
                e_x  = r_cx; e_y = r_cy; e_z = r_cz;
            end
            ST_FEMIT: begin
                emit = 1'b1; e_a = r_cid; e_b = r_prev; e_c = r_cur;
            end
            ST_FLAST: begin
                emit = 1'b1; e_a = r_cid; e_b = r_prev; e_c = r_first; e_last = 1'b1;
            end
            default: ;
        endcase
    end

    assign out_free = !r_o_valid || pop;
    assign out_ld   = emit && out_free;
    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
    assign o_rel    = '{valid: (r_state == ST_DONE), bank: r_bank};

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_bank <= q_bank;
                r_n    <= q_n;
                r_sx   <= q_sx;
                r_sy   <= q_sy;
                r_sz   <= q_sz;
                r_dsel <= '0;
            end
            ST_CAP: begin
                if (is_tri || is_quad) begin
                    r_vid[r_k[1:0]] <= rd_id;
                    r_vp[r_k[1:0]]  <= rd_p;
                    r_area          <= '0;
                end else if (r_k == '0) begin
                    r_first <= rd_id;
                    r_prev  <= rd_id;
                end else begin
                    r_cur <= rd_id;
                end
            end
            ST_DIFF: begin
                r_dux  <= dif(pa[3*CW-1 -: CW], pb[3*CW-1 -: CW]);
                r_duy  <= dif(pa[2*CW-1 -: CW], pb[2*CW-1 -: CW]);
                r_duz  <= dif(pa[CW-1:0], pb[CW-1:0]);
                r_dvx  <= dif(pa[3*CW-1 -: CW], pc[3*CW-1 -: CW]);
                r_dvy  <= dif(pa[2*CW-1 -: CW], pc[2*CW-1 -: CW]);
                r_dvz  <= dif(pa[CW-1:0], pc[CW-1:0]);
                r_acc  <= '0;
                r_term <= '0;
            end
            ST_WP: begin
                if (mul_done) begin
                    r_p  <= q_prod;
                    r_sp <= op_a[DFW-1] ^ op_b[DFW-1];
                end
            end
            ST_WQ: begin
                if (mul_done) begin
                    r_cross <= cross_n;
                end
            end
            ST_WS: begin
                if (mul_done) begin
                    r_acc <= acc_n;
                    if (r_term == 2'd2) begin
                        r_ar[r_area] <= acc_n;
                        r_area       <= r_area + 1'b1;
                    end else begin
                        r_term <= r_term + 1'b1;
                    end
                end
            end
            ST_SORT: begin
                r_mx0 <= (r_ar[0] >= r_ar[1]) ? r_ar[0] : r_ar[1];
                r_mn0 <= (r_ar[0] >= r_ar[1]) ? r_ar[1] : r_ar[0];
                r_mx1 <= (r_ar[2] >= r_ar[3]) ? r_ar[2] : r_ar[3];
                r_mn1 <= (r_ar[2] >= r_ar[3]) ? r_ar[3] : r_ar[2];
            end
            ST_WL: begin
                if (mul_done) begin
                    r_lhs <= mul_prod;
                end
            end
            ST_WR: begin
                if (mul_done) begin
                    r_use13 <= (r_lhs < mul_prod);
                end
            end
            ST_WD: begin
                if (div_done) begin
                    unique case (r_dsel)
                        2'd1:    r_cy <= div_quo;
                        2'd2:    r_cz <= div_quo;
                        default: r_cx <= div_quo;
                    endcase
                    r_dsel <= r_dsel + 1'b1;
                end
            end
            ST_CEN: begin
                r_cid <= r_next_point;
            end
            ST_FEMIT: begin
                if (out_free) begin
                    r_prev <= r_cur;
                end
            end
            default: ;
        endcase
        if (out_ld) begin
            r_o_kind <= e_kind;
            r_o_a    <= e_a;
            r_o_b    <= e_b;
            r_o_c    <= e_c;
            r_o_x    <= e_x;
            r_o_y    <= e_y;
            r_o_z    <= e_z;
            r_o_last <= e_last;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_k          <= '0;
            r_next_point <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (out_ld) begin
                r_o_valid <= 1'b1;
            end else if (pop) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_next_point <= i_cfg_wdata;
            end else if ((r_state == ST_CEN) && out_free) begin
                r_next_point <= r_next_point + 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    if (!i_q_empty) begin
                        r_state <= ((q_n == CNT_W'(3)) || (q_n == CNT_W'(4))) ? ST_RD : ST_DIV;
                    end
                end
                ST_RD: r_state <= ST_CAP;
                ST_CAP: begin
                    priority if (is_tri || is_quad) begin
                        if (k_last) begin
                            r_state <= is_tri ? ST_TRI : ST_DIFF;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_RD;
                        end
                    end else if (r_k == '0) begin
                        if (k_last) begin
                            r_state <= ST_FLAST;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_RD;
                        end
                    end else begin
                        r_state <= ST_FEMIT;
                    end
                end
                ST_TRI:  if (out_free) r_state <= ST_DONE;
                ST_DIFF: r_state <= ST_MULP;
                ST_MULP: r_state <= ST_WP;
                ST_WP:   if (mul_done) r_state <= ST_MULQ;
                ST_MULQ: r_state <= ST_WQ;
                ST_WQ:   if (mul_done) r_state <= ST_MULS;
                ST_MULS: r_state <= ST_WS;
                ST_WS: begin
                    if (mul_done) begin
                        priority if (r_term != 2'd2) begin
                            r_state <= ST_MULP;
                        end else if (r_area == 2'd3) begin
                            r_state <= ST_SORT;
                        end else begin
                            r_state <= ST_DIFF;
                        end
                    end
                end
                ST_SORT: r_state <= ST_MULL;
                ST_MULL: r_state <= ST_WL;
                ST_WL:   if (mul_done) r_state <= ST_MULR;
                ST_MULR: r_state <= ST_WR;
                ST_WR:   if (mul_done) r_state <= ST_Q0;
                ST_Q0:   if (out_free) r_state <= ST_Q1;
                ST_Q1:   if (out_free) r_state <= ST_DONE;
                ST_DIV:  r_state <= ST_WD;
                ST_WD: begin
                    if (div_done) begin
                        r_state <= (r_dsel == 2'd2) ? ST_CEN : ST_DIV;
                    end
                end
                ST_CEN: begin
                    if (out_free) begin
                        r_k     <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_FEMIT: begin
                    if (out_free) begin
                        if (k_last) begin
                            r_state <= ST_FLAST;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_FLAST: if (out_free) r_state <= ST_DONE;
                ST_DONE:  r_state <= ST_IDLE;
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    assign empty       = !r_o_valid;
    assign o_item_kind = r_o_kind;
    assign o_corner_a  = r_o_a;
    assign o_corner_b  = r_o_b;
    assign o_corner_c  = r_o_c;
    assign o_center_x  = r_o_x;
    assign o_center_y  = r_o_y;
    assign o_center_z  = r_o_z;
    assign o_run_last  = r_o_last;

endmodule

`default_nettype wire
